// ===== rtl/sfts_pkg.sv =====
// Shared types and codes for the sorted flag table with subset match.
package sfts_pkg;

    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_UNSET = 2'd1;
    localparam logic [1:0] CMD_MATCH = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    localparam int STATUS_BITS = 2;
    localparam int CMD_BITS    = 2;

    // Per-cell update broadcast to the whole row.
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_INSERT = 3'd2,
        OP_REMOVE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

endpackage

// ===== rtl/sorted_flag_table_subset_match.sv =====
// Top level: sorted flag table built as a row of cells, with command sequencer.
//
// Input words arrive on s_tvalid/s_tready: s_tuser carries the command (set,
// unset, match, clear), s_tdata the key and the value handle. Each word gives
// exactly one result word on m_tvalid/m_tready, carrying found and status in
// m_tuser and value, matched key and entry count in m_tdata.
// Entries sit in a row of DEPTH cells kept in ascending key order; a set that
// inserts a new key and a successful unset shift the row by one cell, all cells together.
// Set, unset and clear go from accept to the update step, then to the output
// register. Match first runs a scan: the match token walks the cell row one
// cell per cycle, and the highest cell whose key is a subset of the query wins.
// One word is worked at a time; the next word is accepted once the previous
// one has reached the output register, so a held result does not block it.
// If the receiver stalls, the finished result waits in the output register
// and the next word stalls before its update step.
// Reset empties the table and drops any pending result; no clearing pass.
module sorted_flag_table_subset_match #(
    parameter int DEPTH      = 16,
    parameter int FLAG_BITS  = 16,
    parameter int VALUE_BITS = 32,
    localparam int CNT_W  = $clog2(DEPTH + 1),
    localparam int IN_W   = ((FLAG_BITS + VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_W  = ((VALUE_BITS + FLAG_BITS + CNT_W + 7) / 8) * 8,
    localparam int OUSR_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,  // state_flags, entry_value
    input  logic [7:0]        s_tuser,  // command
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,  // result_value, matched_flags, entry_count
    output logic [OUSR_W-1:0] m_tuser   // found, status
);

    localparam int CW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sfts_pkg::state_t state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [1:0]            cmd_reg;
    logic [FLAG_BITS-1:0]  key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  m_valid_reg;
    logic                  found_reg, found_next;
    logic [VALUE_BITS-1:0] rval_reg, rval_next;
    logic [FLAG_BITS-1:0]  rkey_reg, rkey_next;
    logic [1:0]            status_reg, status_next;

    logic                  accept;
    logic                  apply_go;
    logic                  exact_any;
    logic                  full;
    sfts_pkg::op_t         op;

    logic                  c_valid [DEPTH+2];
    logic [FLAG_BITS-1:0]  c_key   [DEPTH+2];
    logic [VALUE_BITS-1:0] c_val   [DEPTH+2];
    logic                  c_gt    [DEPTH+1];
    logic [DEPTH-1:0]      c_exact;
    logic                  t_found [DEPTH+1];
    logic [FLAG_BITS-1:0]  t_key   [DEPTH+1];
    logic [VALUE_BITS-1:0] t_val   [DEPTH+1];

    assign c_valid[0]       = 1'b0;
    assign c_key[0]         = '0;
    assign c_val[0]         = '0;
    assign c_valid[DEPTH+1] = 1'b0;
    assign c_key[DEPTH+1]   = '0;
    assign c_val[DEPTH+1]   = '0;
    assign c_gt[0]          = 1'b0;
    assign t_found[0]       = 1'b0;
    assign t_key[0]         = '0;
    assign t_val[0]         = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        sfts_cell #(
            .FLAG_BITS  (FLAG_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .op           (op),
            .q_key        (key_reg),
            .q_val        (val_reg),
            .prev_valid   (c_valid[i]),
            .prev_key     (c_key[i]),
            .prev_val     (c_val[i]),
            .prev_gt      (c_gt[i]),
            .next_valid   (c_valid[i+2]),
            .next_key     (c_key[i+2]),
            .next_val     (c_val[i+2]),
            .tok_in_found (t_found[i]),
            .tok_in_key   (t_key[i]),
            .tok_in_val   (t_val[i]),
            .valid        (c_valid[i+1]),
            .key          (c_key[i+1]),
            .val          (c_val[i+1]),
            .gt           (c_gt[i+1]),
            .exact        (c_exact[i]),
            .tok_found    (t_found[i+1]),
            .tok_key      (t_key[i+1]),
            .tok_val      (t_val[i+1])
        );
    end

    assign exact_any = |c_exact;
    assign full      = c_valid[DEPTH];
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == sfts_pkg::S_IDLE);
    assign apply_go  = (state_reg == sfts_pkg::S_APPLY) && (!m_valid_reg || m_tready);

    always_comb begin
        op          = sfts_pkg::OP_NONE;
        count_next  = count_reg;
        found_next  = 1'b0;
        rval_next   = '0;
        rkey_next   = '0;
        status_next = sfts_pkg::ST_OK;
        if (apply_go) begin
            case (cmd_reg)
                sfts_pkg::CMD_SET: begin
                    if (exact_any) begin
                        op = sfts_pkg::OP_WRITE;
                    end else if (full) begin
                        status_next = sfts_pkg::ST_FULL;
                    end else begin
                        op         = sfts_pkg::OP_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                sfts_pkg::CMD_UNSET: begin
                    if (exact_any) begin
                        op         = sfts_pkg::OP_REMOVE;
                        count_next = count_reg - 1'b1;
                        found_next = 1'b1;
                    end else begin
                        status_next = sfts_pkg::ST_MISSING;
                    end
                end
                sfts_pkg::CMD_MATCH: begin
                    if (t_found[DEPTH]) begin
                        found_next = 1'b1;
                        rval_next  = t_val[DEPTH];
                        rkey_next  = t_key[DEPTH];
                    end else begin
                        status_next = sfts_pkg::ST_MISSING;
                    end
                end
                sfts_pkg::CMD_CLEAR: begin
                    op         = sfts_pkg::OP_CLEAR;
                    count_next = '0;
                end
                default: begin
                    op = sfts_pkg::OP_NONE;
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            sfts_pkg::S_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    if (s_tuser[1:0] == sfts_pkg::CMD_MATCH) begin
                        state_next = sfts_pkg::S_SCAN;
                    end else begin
                        state_next = sfts_pkg::S_APPLY;
                    end
                end
            end
            sfts_pkg::S_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DEPTH - 1)) begin
                    state_next = sfts_pkg::S_APPLY;
                end
            end
            sfts_pkg::S_APPLY: begin
                if (apply_go) begin
                    state_next = sfts_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = sfts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sfts_pkg::S_IDLE;
            cnt_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            count_reg <= count_next;
            if (apply_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_tuser[1:0];
            key_reg <= s_tdata[FLAG_BITS-1:0];
            val_reg <= s_tdata[FLAG_BITS+VALUE_BITS-1:FLAG_BITS];
        end
        if (apply_go) begin
            found_reg  <= found_next;
            rval_reg   <= rval_next;
            rkey_reg   <= rkey_next;
            status_reg <= status_next;
        end
    end

    logic [CNT_W-1:0] count_out_reg;

    always_ff @(posedge aclk) begin
        if (apply_go) begin
            count_out_reg <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({count_out_reg, rkey_reg, rval_reg});
    assign m_tuser  = OUSR_W'({status_reg, found_reg});

endmodule

// ===== rtl/sfts_cell.sv =====
// One table cell: holds a key/value entry and passes a match token to the next cell.
module sfts_cell #(
    parameter int FLAG_BITS  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sfts_pkg::op_t         op,
    input  logic [FLAG_BITS-1:0]  q_key,
    input  logic [VALUE_BITS-1:0] q_val,
    input  logic                  prev_valid,
    input  logic [FLAG_BITS-1:0]  prev_key,
    input  logic [VALUE_BITS-1:0] prev_val,
    input  logic                  prev_gt,
    input  logic                  next_valid,
    input  logic [FLAG_BITS-1:0]  next_key,
    input  logic [VALUE_BITS-1:0] next_val,
    input  logic                  tok_in_found,
    input  logic [FLAG_BITS-1:0]  tok_in_key,
    input  logic [VALUE_BITS-1:0] tok_in_val,
    output logic                  valid,
    output logic [FLAG_BITS-1:0]  key,
    output logic [VALUE_BITS-1:0] val,
    output logic                  gt,
    output logic                  exact,
    output logic                  tok_found,
    output logic [FLAG_BITS-1:0]  tok_key,
    output logic [VALUE_BITS-1:0] tok_val
);

    logic                  valid_reg, valid_next;
    logic [FLAG_BITS-1:0]  key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  tok_found_reg;
    logic [FLAG_BITS-1:0]  tok_key_reg;
    logic [VALUE_BITS-1:0] tok_val_reg;
    logic                  ge;
    logic                  cand;

    assign gt    = !valid_reg || (key_reg > q_key);
    assign ge    = !valid_reg || (key_reg >= q_key);
    assign exact = valid_reg && (key_reg == q_key);
    // zero key, exact key and nonempty subsets all satisfy this
    assign cand  = valid_reg && ((key_reg & ~q_key) == '0);

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        case (op)
            sfts_pkg::OP_WRITE: begin
                if (exact) begin
                    val_next = q_val;
                end
            end
            sfts_pkg::OP_INSERT: begin
                if (prev_gt) begin
                    valid_next = prev_valid;
                    key_next   = prev_key;
                    val_next   = prev_val;
                end else if (gt) begin
                    valid_next = 1'b1;
                    key_next   = q_key;
                    val_next   = q_val;
                end
            end
            sfts_pkg::OP_REMOVE: begin
                if (ge) begin
                    valid_next = next_valid;
                    key_next   = next_key;
                    val_next   = next_val;
                end
            end
            sfts_pkg::OP_CLEAR: begin
                valid_next = 1'b0;
            end
            default: begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            tok_found_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            tok_found_reg <= cand || tok_in_found;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        val_reg <= val_next;
        if (cand) begin
            tok_key_reg <= key_reg;
            tok_val_reg <= val_reg;
        end else begin
            tok_key_reg <= tok_in_key;
            tok_val_reg <= tok_in_val;
        end
    end

    assign valid     = valid_reg;
    assign key       = key_reg;
    assign val       = val_reg;
    assign tok_found = tok_found_reg;
    assign tok_key   = tok_key_reg;
    assign tok_val   = tok_val_reg;

endmodule
